/* sv/hrhc_pkg.sv */
package hrhc_pkg;

    typedef enum logic [2:0] {
        PH_METHOD     = 3'd0,
        PH_PATH       = 3'd1,
        PH_VERSION    = 3'd2,
        PH_VERSION_LF = 3'd3,
        PH_NAME       = 3'd4,
        PH_VALUE      = 3'd5,
        PH_BLANK_LF   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_METHOD = 3'd0,
        KIND_PATH   = 3'd1,
        KIND_USED   = 3'd2,
        KIND_ACCEPT = 3'd3,
        KIND_REJECT = 3'd4
    } kind_t;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] CONN_LEN    = 4'd10;
    localparam logic [3:0] CLEN_LEN    = 4'd14;
    localparam logic [3:0] CLOSE_LEN   = 4'd5;
    localparam logic [3:0] KA_LEN      = 4'd10;
    localparam logic [3:0] POS_MAX     = 4'd15;

    localparam logic [1:0] ZONE_LEAD  = 2'd0;
    localparam logic [1:0] ZONE_TEXT  = 2'd1;
    localparam logic [1:0] ZONE_TRAIL = 2'd2;

    localparam logic [1:0] NAME_HITS_ALL  = 2'b11;
    localparam logic [2:0] VALUE_HITS_ALL = 3'b111;

    typedef struct packed {
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       close_conn;
    } res_t;

    typedef struct packed {
        logic [3:0] pos;
        logic [2:0] hits;
        logic [1:0] zone;
    } value_st_t;

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0: c = "H";
            3'd1: c = "T";
            3'd2: c = "T";
            3'd3: c = "P";
            3'd4: c = "/";
            3'd5: c = "1";
            3'd6: c = ".";
            default: c = "1";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] conn_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0: c = "c";
            4'd1: c = "o";
            4'd2: c = "n";
            4'd3: c = "n";
            4'd4: c = "e";
            4'd5: c = "c";
            4'd6: c = "t";
            4'd7: c = "i";
            4'd8: c = "o";
            4'd9: c = "n";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:  c = "c";
            4'd1:  c = "o";
            4'd2:  c = "n";
            4'd3:  c = "t";
            4'd4:  c = "e";
            4'd5:  c = "n";
            4'd6:  c = "t";
            4'd7:  c = "-";
            4'd8:  c = "l";
            4'd9:  c = "e";
            4'd10: c = "n";
            4'd11: c = "g";
            4'd12: c = "t";
            4'd13: c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] close_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0: c = "c";
            4'd1: c = "l";
            4'd2: c = "o";
            4'd3: c = "s";
            4'd4: c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ka_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0: c = "k";
            4'd1: c = "e";
            4'd2: c = "e";
            4'd3: c = "p";
            4'd4: c = "-";
            4'd5: c = "a";
            4'd6: c = "l";
            4'd7: c = "i";
            4'd8: c = "v";
            4'd9: c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // fold one value byte into the match state
    function automatic value_st_t value_step(input value_st_t st, input logic [7:0] c);
        value_st_t r;
        r = st;
        if (c == CH_SPACE) begin
            if (st.zone == ZONE_TEXT) begin
                r.zone = ZONE_TRAIL;
            end
        end else begin
            if (st.zone == ZONE_TRAIL) begin
                r.hits = 3'b000;
            end
            r.zone = ZONE_TEXT;
            if (close_char(st.pos) != c) begin
                r.hits[0] = 1'b0;
            end
            if (ka_char(st.pos) != c) begin
                r.hits[1] = 1'b0;
            end
            if (c != CH_ZERO) begin
                r.hits[2] = 1'b0;
            end
            if (st.pos != POS_MAX) begin
                r.pos = st.pos + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

/* sv/hrhc_stream_if.sv */
interface hrhc_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/http_request_header_checker_top.sv */
// channel | dir | payload                      | handshake
// req     | in  | rx_byte[7:0]                 | valid/ready
// res     | out | kind[2:0] data[7:0] close_conn | valid/ready
//
// One result per byte; a new byte is taken every cycle unless a stalled result holds the stages.
// The path is the input register, then the parse step into the result register.
// The per-byte parse state updates on the same edge that loads the result register.
// A stalled result holds both stages; the input register still fills while the result waits, if it is empty.
// rst_n clears all parse state to the start of a request.
module http_request_header_checker_top (
    input logic          clk,
    input logic          rst_n,
    hrhc_stream_if.sink   req,
    hrhc_stream_if.source res
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    hrhc_pkg::res_t out_reg;

    hrhc_pkg::phase_t phase_reg, phase_next;
    logic [3:0] version_pos_reg, version_pos_next;
    logic [3:0] name_pos_reg, name_pos_next;
    logic [1:0] name_hits_reg, name_hits_next;
    hrhc_pkg::value_st_t value_reg, value_next;
    logic       cr_held_reg, cr_held_next;
    logic       seen_conn_reg, seen_conn_next;
    logic       seen_len_reg, seen_len_next;
    logic       close_seen_reg, close_seen_next;

    hrhc_pkg::kind_t kind_c;
    hrhc_pkg::value_st_t vst_c;
    logic [7:0] b;
    logic [7:0] lc;
    logic       ctl;
    logic       filled, is_close, is_ka, zeros, done_ok;
    logic [1:0] nh;
    logic       advance;
    logic       fire;

    assign advance   = !out_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

    always_comb
    begin
        b   = in_byte_reg;
        ctl = (b >= 8'd9) && (b <= 8'd13);
        lc  = ((b >= "A") && (b <= "Z")) ? (b + 8'd32) : b;
        vst_c = value_reg;
        nh = 2'b00;
        filled = 1'b0;
        is_close = 1'b0;
        is_ka = 1'b0;
        zeros = 1'b0;
        done_ok = 1'b1;

        phase_next       = phase_reg;
        version_pos_next = version_pos_reg;
        name_pos_next    = name_pos_reg;
        name_hits_next   = name_hits_reg;
        value_next       = value_reg;
        cr_held_next     = cr_held_reg;
        seen_conn_next   = seen_conn_reg;
        seen_len_next    = seen_len_reg;
        close_seen_next  = close_seen_reg;
        kind_c           = hrhc_pkg::KIND_REJECT;

        if ((b != 8'h00) && !b[7])
        begin
            unique case (phase_reg)
                hrhc_pkg::PH_METHOD, hrhc_pkg::PH_PATH:
                begin
                    if (b == hrhc_pkg::CH_SPACE)
                    begin
                        phase_next = (phase_reg == hrhc_pkg::PH_METHOD) ?
                                     hrhc_pkg::PH_PATH : hrhc_pkg::PH_VERSION;
                        kind_c = hrhc_pkg::KIND_USED;
                    end
                    else if (!ctl)
                    begin
                        kind_c = (phase_reg == hrhc_pkg::PH_METHOD) ?
                                 hrhc_pkg::KIND_METHOD : hrhc_pkg::KIND_PATH;
                    end
                end
                hrhc_pkg::PH_VERSION:
                begin
                    if (version_pos_reg < hrhc_pkg::VERSION_LEN)
                    begin
                        if (b == hrhc_pkg::version_char(version_pos_reg[2:0]))
                        begin
                            version_pos_next = version_pos_reg + 4'd1;
                            kind_c = hrhc_pkg::KIND_USED;
                        end
                    end
                    else if (b == hrhc_pkg::CH_CR)
                    begin
                        phase_next = hrhc_pkg::PH_VERSION_LF;
                        kind_c = hrhc_pkg::KIND_USED;
                    end
                end
                hrhc_pkg::PH_VERSION_LF:
                begin
                    if (b == hrhc_pkg::CH_LF)
                    begin
                        phase_next     = hrhc_pkg::PH_NAME;
                        name_pos_next  = 4'd0;
                        name_hits_next = hrhc_pkg::NAME_HITS_ALL;
                        kind_c = hrhc_pkg::KIND_USED;
                    end
                end
                hrhc_pkg::PH_NAME:
                begin
                    if ((name_pos_reg == 4'd0) && (b == hrhc_pkg::CH_CR))
                    begin
                        phase_next = hrhc_pkg::PH_BLANK_LF;
                        kind_c = hrhc_pkg::KIND_USED;
                    end
                    else if (b == hrhc_pkg::CH_COLON)
                    begin
                        if (name_pos_reg != 4'd0)
                        begin
                            nh[0] = name_hits_reg[0] && (name_pos_reg == hrhc_pkg::CONN_LEN);
                            nh[1] = name_hits_reg[1] && (name_pos_reg == hrhc_pkg::CLEN_LEN);
                            name_hits_next = nh;
                            phase_next = hrhc_pkg::PH_VALUE;
                            value_next.pos  = 4'd0;
                            value_next.hits = hrhc_pkg::VALUE_HITS_ALL;
                            value_next.zone = hrhc_pkg::ZONE_LEAD;
                            cr_held_next = 1'b0;
                            kind_c = hrhc_pkg::KIND_USED;
                        end
                    end
                    else if ((b != hrhc_pkg::CH_SPACE) && !ctl)
                    begin
                        if (hrhc_pkg::conn_char(name_pos_reg) != lc)
                        begin
                            name_hits_next[0] = 1'b0;
                        end
                        if (hrhc_pkg::clen_char(name_pos_reg) != lc)
                        begin
                            name_hits_next[1] = 1'b0;
                        end
                        if (name_pos_reg != hrhc_pkg::POS_MAX)
                        begin
                            name_pos_next = name_pos_reg + 4'd1;
                        end
                        kind_c = hrhc_pkg::KIND_USED;
                    end
                end
                hrhc_pkg::PH_VALUE:
                begin
                    if (b == hrhc_pkg::CH_LF)
                    begin
                        filled   = (value_reg.zone != hrhc_pkg::ZONE_LEAD);
                        is_close = filled && value_reg.hits[0] &&
                                   (value_reg.pos == hrhc_pkg::CLOSE_LEN);
                        is_ka    = filled && value_reg.hits[1] &&
                                   (value_reg.pos == hrhc_pkg::KA_LEN);
                        zeros    = filled && value_reg.hits[2];
                        if (name_hits_reg[0])
                        begin
                            seen_conn_next = 1'b1;
                            if (is_close)
                            begin
                                close_seen_next = 1'b1;
                            end
                            done_ok = !seen_conn_reg && (is_close || is_ka);
                        end
                        else if (name_hits_reg[1])
                        begin
                            seen_len_next = 1'b1;
                            done_ok = !seen_len_reg && zeros;
                        end
                        if (cr_held_reg && done_ok)
                        begin
                            cr_held_next   = 1'b0;
                            phase_next     = hrhc_pkg::PH_NAME;
                            name_pos_next  = 4'd0;
                            name_hits_next = hrhc_pkg::NAME_HITS_ALL;
                            kind_c = hrhc_pkg::KIND_USED;
                        end
                    end
                    else
                    begin
                        if (cr_held_reg)
                        begin
                            vst_c = hrhc_pkg::value_step(value_reg, hrhc_pkg::CH_CR);
                        end
                        if (b == hrhc_pkg::CH_CR)
                        begin
                            cr_held_next = 1'b1;
                            value_next   = vst_c;
                        end
                        else
                        begin
                            cr_held_next = 1'b0;
                            value_next   = hrhc_pkg::value_step(vst_c, b);
                        end
                        kind_c = hrhc_pkg::KIND_USED;
                    end
                end
                hrhc_pkg::PH_BLANK_LF:
                begin
                    if (b == hrhc_pkg::CH_LF)
                    begin
                        kind_c = hrhc_pkg::KIND_ACCEPT;
                    end
                end
                default:
                begin
                    kind_c = hrhc_pkg::KIND_REJECT;
                end
            endcase
        end

        if ((kind_c == hrhc_pkg::KIND_ACCEPT) || (kind_c == hrhc_pkg::KIND_REJECT))
        begin
            phase_next       = hrhc_pkg::PH_METHOD;
            version_pos_next = 4'd0;
            name_pos_next    = 4'd0;
            name_hits_next   = hrhc_pkg::NAME_HITS_ALL;
            value_next.pos   = 4'd0;
            value_next.hits  = hrhc_pkg::VALUE_HITS_ALL;
            value_next.zone  = hrhc_pkg::ZONE_LEAD;
            cr_held_next     = 1'b0;
            seen_conn_next   = 1'b0;
            seen_len_next    = 1'b0;
            close_seen_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= hrhc_pkg::PH_METHOD;
            version_pos_reg <= 4'd0;
            name_pos_reg    <= 4'd0;
            name_hits_reg   <= hrhc_pkg::NAME_HITS_ALL;
            value_reg.pos   <= 4'd0;
            value_reg.hits  <= hrhc_pkg::VALUE_HITS_ALL;
            value_reg.zone  <= hrhc_pkg::ZONE_LEAD;
            cr_held_reg     <= 1'b0;
            seen_conn_reg   <= 1'b0;
            seen_len_reg    <= 1'b0;
            close_seen_reg  <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                phase_reg       <= phase_next;
                version_pos_reg <= version_pos_next;
                name_pos_reg    <= name_pos_next;
                name_hits_reg   <= name_hits_next;
                value_reg       <= value_next;
                cr_held_reg     <= cr_held_next;
                seen_conn_reg   <= seen_conn_next;
                seen_len_reg    <= seen_len_next;
                close_seen_reg  <= close_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_byte_reg <= req.payload.rx_byte;
        end
        if (fire)
        begin
            out_reg.kind       <= kind_c;
            out_reg.data       <= in_byte_reg;
            out_reg.close_conn <= (kind_c == hrhc_pkg::KIND_ACCEPT) && close_seen_reg;
        end
    end

    a_close_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.close_conn) |-> (out_reg.kind == hrhc_pkg::KIND_ACCEPT))
        else $error("close_conn set on a non-accept result");

    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ((kind_c == hrhc_pkg::KIND_ACCEPT) || (kind_c == hrhc_pkg::KIND_REJECT)))
        |=> ((phase_reg == hrhc_pkg::PH_METHOD) && !seen_conn_reg && !seen_len_reg
             && !close_seen_reg))
        else $error("parse state not cleared after verdict");

    a_version_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        version_pos_reg[3] |-> (version_pos_reg[2:0] == 3'd0))
        else $error("version position past end of version text");

    a_echo_data: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && (out_reg.data == $past(in_byte_reg))))
        else $error("result does not echo the processed byte");

endmodule
